@@ design/stli_pkg.sv @@
package stli_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_Y_AT_X = 2'd2,
        KIND_X_AT_Y = 2'd3
    } kind_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [2:0]                pad;
        logic signed [VALUE_W-1:0] highest_y;
        logic signed [VALUE_W-1:0] lowest_y;
        logic signed [VALUE_W-1:0] highest_x;
        logic signed [VALUE_W-1:0] lowest_x;
        logic [COUNT_W-1:0]        entry_count;
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] answer;
    } result_t;

endpackage

@@ design/sorted_table_linear_interpolator_core.sv @@
// Sorted (x,y) table in signed Q16.16 with piecewise-linear lookup. Items enter on the s_
// channel (kind on s_tuser: clear, insert, y at x, x at y) and each gives one result on the
// m_ channel carrying the answer, a status, the entry count and the running x/y extremes.
// The block takes one item at a time; s_tready is high only while it waits for an item.
// Everything runs through one read port per table memory and one 32-bit divide step, so the
// time per item depends on its kind: an out-of-order insert grows with the binary search
// and with the entries moved, and an interpolating lookup also waits on the bit-serial
// divider.
// A waiting result sits in the output register while the next item is accepted.
module sorted_table_linear_interpolator_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // point_x[31:0], point_y[63:32]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // answer[31:0], status[33:32], entry_count[44:34], lowest_x[76:45],
    // highest_x[108:77], lowest_y[140:109], highest_y[172:141], zeros[175:173]
    output logic [175:0] m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [22:0] {
        ST_IDLE      = 23'h000001,
        ST_DECODE    = 23'h000002,
        ST_LAST_RD   = 23'h000004,
        ST_LAST_CMP  = 23'h000008,
        ST_FIRST_RD  = 23'h000010,
        ST_FIRST_CMP = 23'h000020,
        ST_BS_RD     = 23'h000040,
        ST_BS_CMP    = 23'h000080,
        ST_SH_CHK    = 23'h000100,
        ST_SH_RD     = 23'h000200,
        ST_SH_WR     = 23'h000400,
        ST_PUT       = 23'h000800,
        ST_END_RD    = 23'h001000,
        ST_END_SEL   = 23'h002000,
        ST_P0_RD     = 23'h004000,
        ST_P1_RD     = 23'h008000,
        ST_PREP      = 23'h010000,
        ST_NORM      = 23'h020000,
        ST_MUL       = 23'h040000,
        ST_ADD       = 23'h080000,
        ST_DIV       = 23'h100000,
        ST_FIN       = 23'h200000,
        ST_DONE      = 23'h400000
    } state_t;

    state_t state_reg, state_next;
    stli_pkg::kind_t kind_reg, kind_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] answer_reg, answer_next;
    logic [1:0]         status_reg, status_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] minx_reg, minx_next, maxx_reg, maxx_next;
    logic signed [31:0] miny_reg, miny_next, maxy_reg, maxy_next;
    logic [AW-1:0]      s_reg, s_next, e_reg, e_next, i_reg, i_next;
    logic [AW-1:0]      pos_reg, pos_next, addr_reg, addr_next;
    logic signed [31:0] k0_reg, k0_next, v0_reg, v0_next, v1_reg, v1_next;
    logic signed [32:0] n_reg, n_next, d_reg, d_next, da_reg, da_next;
    logic               neg_reg, neg_next;
    logic [31:0]        mag_reg, mag_next;
    logic [63:0]        prod_reg, prod_next;
    logic [31:0]        rem_reg, rem_next, dvd_reg, dvd_next;
    logic [4:0]         bit_reg, bit_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [175:0]       m_tdata_reg, m_tdata_next;

    // Table memories
    logic signed [31:0] x_mem [TABLE_DEPTH];
    logic signed [31:0] y_mem [TABLE_DEPTH];
    logic signed [31:0] x_rd_reg, y_rd_reg;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_x, wr_y;

    // Shared combinational terms
    logic               key_is_x;
    logic signed [31:0] key, rd_key, rd_val, lo_seen, hi_seen;
    logic [AW-1:0]      last_idx, mid, s_upd, e_upd;
    logic               key_above;
    logic signed [32:0] dn, nn;
    logic [63:0]        dividend;
    logic [32:0]        trial;
    logic [31:0]        cnt32;
    stli_pkg::result_t  res;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign key_is_x = (kind_reg != stli_pkg::KIND_X_AT_Y);
    assign key      = key_is_x ? px_reg : py_reg;
    assign rd_key   = key_is_x ? x_rd_reg : y_rd_reg;
    assign rd_val   = key_is_x ? y_rd_reg : x_rd_reg;
    assign lo_seen  = key_is_x ? minx_reg : miny_reg;
    assign hi_seen  = key_is_x ? maxx_reg : maxy_reg;
    assign last_idx = AW'(count_reg - CW'(1));
    assign mid      = AW'(({1'b0, s_reg} + {1'b0, e_reg}) >> 1);
    assign key_above = (key > rd_key);
    assign s_upd    = key_above ? addr_reg : s_reg;
    assign e_upd    = key_above ? e_reg : addr_reg;
    assign dn       = d_reg[32] ? -d_reg : d_reg;
    assign nn       = d_reg[32] ? -n_reg : n_reg;
    assign dividend = prod_reg + {32'd0, d_reg[32:1]};
    assign trial    = {rem_reg, dvd_reg[31]};
    assign cnt32    = 32'(count_reg);

    // Select the read address for the current step
    always_comb begin
        case (state_reg)
            ST_BS_RD: rd_addr = mid;
            ST_SH_RD: rd_addr = i_reg - AW'(1);
            ST_P0_RD: rd_addr = s_reg;
            ST_P1_RD: rd_addr = s_reg + AW'(1);
            default:  rd_addr = addr_reg;
        endcase
    end

    // Write either a moved entry or the new point
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_x    = px_reg;
        wr_y    = py_reg;
        if (state_reg == ST_SH_WR) begin
            wr_en   = 1'b1;
            wr_addr = i_reg;
            wr_x    = x_rd_reg;
            wr_y    = y_rd_reg;
        end else if (state_reg == ST_PUT) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    // Pack the outgoing result
    always_comb begin
        res.pad         = '0;
        res.answer      = answer_reg;
        res.status      = status_reg;
        res.entry_count = cnt32[10:0];
        res.lowest_x    = minx_reg;
        res.highest_x   = maxx_reg;
        res.lowest_y    = miny_reg;
        res.highest_y   = maxy_reg;
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        answer_next   = answer_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        minx_next     = minx_reg;
        maxx_next     = maxx_reg;
        miny_next     = miny_reg;
        maxy_next     = maxy_reg;
        s_next        = s_reg;
        e_next        = e_reg;
        i_next        = i_reg;
        pos_next      = pos_reg;
        addr_next     = addr_reg;
        k0_next       = k0_reg;
        v0_next       = v0_reg;
        v1_next       = v1_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        da_next       = da_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        bit_next      = bit_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = stli_pkg::kind_t'(s_tuser);
                    px_next     = s_tdata[31:0];
                    py_next     = s_tdata[63:32];
                    answer_next = '0;
                    status_next = stli_pkg::STATUS_OK;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (kind_reg)
                    stli_pkg::KIND_CLEAR: begin
                        count_next = '0;
                        minx_next  = stli_pkg::MOST_POS;
                        maxx_next  = stli_pkg::MOST_NEG;
                        miny_next  = stli_pkg::MOST_POS;
                        maxy_next  = stli_pkg::MOST_NEG;
                        state_next = ST_DONE;
                    end
                    stli_pkg::KIND_INSERT: begin
                        if (count_reg >= CW'(TABLE_DEPTH)) begin
                            status_next = stli_pkg::STATUS_FULL;
                            state_next  = ST_DONE;
                        end else begin
                            if (px_reg < minx_reg) minx_next = px_reg;
                            if (px_reg > maxx_reg) maxx_next = px_reg;
                            if (py_reg < miny_reg) miny_next = py_reg;
                            if (py_reg > maxy_reg) maxy_next = py_reg;
                            if (count_reg == '0) begin
                                pos_next   = '0;
                                state_next = ST_PUT;
                            end else begin
                                addr_next  = last_idx;
                                state_next = ST_LAST_RD;
                            end
                        end
                    end
                    default: begin
                        if (count_reg == '0) begin
                            status_next = stli_pkg::STATUS_EMPTY;
                            state_next  = ST_DONE;
                        end else if (key <= lo_seen) begin
                            addr_next  = '0;
                            state_next = ST_END_RD;
                        end else if (key >= hi_seen) begin
                            addr_next  = last_idx;
                            state_next = ST_END_RD;
                        end else begin
                            s_next = '0;
                            e_next = last_idx;
                            state_next = (last_idx > AW'(1)) ? ST_BS_RD : ST_P0_RD;
                        end
                    end
                endcase
            end
            ST_LAST_RD: state_next = ST_LAST_CMP;
            ST_LAST_CMP: begin
                if (px_reg < x_rd_reg) begin
                    addr_next  = '0;
                    state_next = ST_FIRST_RD;
                end else begin
                    pos_next   = AW'(count_reg);
                    state_next = ST_PUT;
                end
            end
            ST_FIRST_RD: state_next = ST_FIRST_CMP;
            ST_FIRST_CMP: begin
                i_next = AW'(count_reg);
                if (px_reg > x_rd_reg) begin
                    s_next = '0;
                    e_next = last_idx;
                    if (last_idx > AW'(1)) begin
                        state_next = ST_BS_RD;
                    end else begin
                        pos_next   = last_idx;
                        state_next = ST_SH_CHK;
                    end
                end else begin
                    pos_next   = '0;
                    state_next = ST_SH_CHK;
                end
            end
            ST_BS_RD: begin
                addr_next  = mid;
                state_next = ST_BS_CMP;
            end
            ST_BS_CMP: begin
                // Narrow the bracket on the probe just read
                s_next = s_upd;
                e_next = e_upd;
                if ((e_upd - s_upd) > AW'(1)) begin
                    state_next = ST_BS_RD;
                end else if (kind_reg == stli_pkg::KIND_INSERT) begin
                    pos_next   = e_upd;
                    i_next     = AW'(count_reg);
                    state_next = ST_SH_CHK;
                end else begin
                    state_next = ST_P0_RD;
                end
            end
            ST_SH_CHK: state_next = (i_reg > pos_reg) ? ST_SH_RD : ST_PUT;
            ST_SH_RD:  state_next = ST_SH_WR;
            ST_SH_WR: begin
                i_next     = i_reg - AW'(1);
                state_next = ST_SH_CHK;
            end
            ST_PUT: begin
                count_next = count_reg + CW'(1);
                state_next = ST_DONE;
            end
            ST_END_RD: state_next = ST_END_SEL;
            ST_END_SEL: begin
                answer_next = rd_val;
                state_next  = ST_DONE;
            end
            ST_P0_RD: state_next = ST_P1_RD;
            ST_P1_RD: begin
                k0_next    = rd_key;
                v0_next    = rd_val;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                v1_next    = rd_val;
                n_next     = 33'(key) - 33'(k0_reg);
                d_next     = 33'(rd_key) - 33'(k0_reg);
                da_next    = 33'(rd_val) - 33'(v0_reg);
                state_next = ST_NORM;
            end
            ST_NORM: begin
                // Clamp the fraction to zero..one, else set up the scaled offset
                if (d_reg == '0 || nn <= 33'sd0) begin
                    answer_next = v0_reg;
                    state_next  = ST_DONE;
                end else if (nn >= dn) begin
                    answer_next = v1_reg;
                    state_next  = ST_DONE;
                end else begin
                    n_next     = nn;
                    d_next     = dn;
                    neg_next   = da_reg[32];
                    mag_next   = da_reg[32] ? 32'(-da_reg) : da_reg[31:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = mag_reg * n_reg[31:0];
                state_next = ST_ADD;
            end
            ST_ADD: begin
                // Add half the divisor to round to nearest
                rem_next   = dividend[63:32];
                dvd_next   = dividend[31:0];
                bit_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // One restoring divide step per cycle
                if (trial >= {1'b0, d_reg[31:0]}) begin
                    rem_next = 32'(trial - {1'b0, d_reg[31:0]});
                    dvd_next = {dvd_reg[30:0], 1'b1};
                end else begin
                    rem_next = trial[31:0];
                    dvd_next = {dvd_reg[30:0], 1'b0};
                end
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'd31) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                answer_next = neg_reg ? (v0_reg - $signed(dvd_reg))
                                      : (v0_reg + $signed(dvd_reg));
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            minx_reg     <= stli_pkg::MOST_POS;
            maxx_reg     <= stli_pkg::MOST_NEG;
            miny_reg     <= stli_pkg::MOST_POS;
            maxy_reg     <= stli_pkg::MOST_NEG;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            minx_reg     <= minx_next;
            maxx_reg     <= maxx_next;
            miny_reg     <= miny_next;
            maxy_reg     <= maxy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        answer_reg  <= answer_next;
        status_reg  <= status_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        i_reg       <= i_next;
        pos_reg     <= pos_next;
        addr_reg    <= addr_next;
        k0_reg      <= k0_next;
        v0_reg      <= v0_next;
        v1_reg      <= v1_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        da_reg      <= da_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        bit_reg     <= bit_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
